// File: src/rbaa_pkg.sv
// Shared constants, types and helpers for the rigid-body angular acceleration block.
`default_nettype none
package rbaa_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int CFG_IDX_W      = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INERTIA_XX = 3'd0,
		REG_INERTIA_YY = 3'd1,
		REG_INERTIA_ZZ = 3'd2,
		REG_PRODUCT_XY = 3'd3,
		REG_PRODUCT_XZ = 3'd4,
		REG_PRODUCT_YZ = 3'd5
	} reg_idx_t;

	// Cofactor slots: diagonal first, then the upper off-diagonal terms.
	localparam int COF_00 = 0;
	localparam int COF_11 = 1;
	localparam int COF_22 = 2;
	localparam int COF_01 = 3;
	localparam int COF_02 = 4;
	localparam int COF_12 = 5;

	// Control flags that travel with each axis through the divider.
	typedef struct packed {
		logic big;
		logic neg;
		logic sing;
		logic ovf;
	} dctl_t;

	// Slot of the symmetric adjugate entry at row i, column j.
	function automatic int cof_sel(input int i, input int j);
		int s;
		s = COF_00;
		if (i == j) begin
			s = i;
		end else if ((i + j) == 1) begin
			s = COF_01;
		end else if ((i + j) == 2) begin
			s = COF_02;
		end else begin
			s = COF_12;
		end
		return s;
	endfunction

endpackage
`default_nettype wire

// File: src/rbaa_adj.sv
// Free-running adjugate and determinant pipeline fed by the inertia registers.
`default_nettype none
module rbaa_adj #(
	parameter int DATA_WIDTH = rbaa_pkg::DATA_WIDTH_DEF
) (
	input  wire                              clk,
	input  wire        [DATA_WIDTH-2:0]      ixx,
	input  wire        [DATA_WIDTH-2:0]      iyy,
	input  wire        [DATA_WIDTH-2:0]      izz,
	input  wire signed [DATA_WIDTH-1:0]      pxy,
	input  wire signed [DATA_WIDTH-1:0]      pxz,
	input  wire signed [DATA_WIDTH-1:0]      pyz,
	output logic signed [2*DATA_WIDTH-1:0]   cof [6],
	output logic       [3*DATA_WIDTH+1:0]    det_mag,
	output logic                             det_neg,
	output logic                             det_zero
);
	localparam int DW   = DATA_WIDTH;
	localparam int PW   = 2 * DW;
	localparam int CW   = 2 * DW;
	localparam int PRW  = 3 * DW;
	localparam int DETW = 3 * DW + 2;

	logic signed [DW-1:0] m00, m11, m22;
	logic signed [PW-1:0] pa_q [6];
	logic signed [PW-1:0] pb_q [6];
	logic signed [CW-1:0] cof_q [6];
	logic signed [PW:0]   dlo_q [3];
	logic signed [PW-1:0] dhi_q [3];
	logic signed [PRW-1:0] dp_q [3];
	logic signed [DW-1:0] mrow [3];
	logic signed [DETW-1:0] dsum;

	assign m00 = $signed({1'b0, ixx});
	assign m11 = $signed({1'b0, iyy});
	assign m22 = $signed({1'b0, izz});
	assign mrow[0] = m00;
	assign mrow[1] = pxy;
	assign mrow[2] = pxz;

	always_ff @(posedge clk) begin
		pa_q[rbaa_pkg::COF_00] <= m11 * m22;  pb_q[rbaa_pkg::COF_00] <= pyz * pyz;
		pa_q[rbaa_pkg::COF_11] <= m00 * m22;  pb_q[rbaa_pkg::COF_11] <= pxz * pxz;
		pa_q[rbaa_pkg::COF_22] <= m00 * m11;  pb_q[rbaa_pkg::COF_22] <= pxy * pxy;
		pa_q[rbaa_pkg::COF_01] <= pxz * pyz;  pb_q[rbaa_pkg::COF_01] <= pxy * m22;
		pa_q[rbaa_pkg::COF_02] <= pxy * pyz;  pb_q[rbaa_pkg::COF_02] <= pxz * m11;
		pa_q[rbaa_pkg::COF_12] <= pxy * pxz;  pb_q[rbaa_pkg::COF_12] <= m00 * pyz;
	end

	// Cofactors keep only their low 2*DW bits, as the wrapped difference.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 6; k++) begin
			cof_q[k] <= pa_q[k] - pb_q[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			dlo_q[j] <= $signed({1'b0, cof_q[rbaa_pkg::cof_sel(0, j)][DW-1:0]}) * mrow[j];
			dhi_q[j] <= $signed(cof_q[rbaa_pkg::cof_sel(0, j)][CW-1:DW]) * mrow[j];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			dp_q[j] <= (PRW'(dhi_q[j]) <<< DW) + PRW'(dlo_q[j]);
		end
	end

	assign dsum = DETW'(dp_q[0]) + DETW'(dp_q[1]) + DETW'(dp_q[2]);

	always_ff @(posedge clk) begin
		det_neg  <= dsum[DETW-1];
		det_zero <= (dsum == '0);
		det_mag  <= dsum[DETW-1] ? DETW'(-dsum) : DETW'(dsum);
	end

	assign cof = cof_q;

endmodule
`default_nettype wire

// File: src/rbaa_div.sv
// Restoring divider, one quotient bit per pipeline stage.
`default_nettype none
module rbaa_div #(
	parameter int DATA_WIDTH = rbaa_pkg::DATA_WIDTH_DEF,
	parameter int NUMW       = 3 * rbaa_pkg::DATA_WIDTH_DEF + 2 + rbaa_pkg::FRAC_BITS_DEF,
	parameter int DETW       = 3 * rbaa_pkg::DATA_WIDTH_DEF + 2
) (
	input  wire                     clk,
	input  wire  [DATA_WIDTH-1:0]   en,
	input  wire  [NUMW-1:0]         num_mag,
	input  wire  [DETW-1:0]         det_mag,
	input  wire  rbaa_pkg::dctl_t   ctl_in,
	output logic [DATA_WIDTH-1:0]   quo,
	output rbaa_pkg::dctl_t         ctl_out
);
	localparam int DW   = DATA_WIDTH;
	localparam int CMPW = (NUMW > DETW + DW) ? NUMW : DETW + DW;

	logic [NUMW-1:0]   rem_q [DW];
	logic [DW-1:0]     quo_q [DW];
	logic [DETW-1:0]   det_q [DW];
	rbaa_pkg::dctl_t   ctl_q [DW];
	logic [NUMW-1:0]   rin   [DW];
	logic [DW-1:0]     qin   [DW];
	logic [DETW-1:0]   din   [DW];
	rbaa_pkg::dctl_t   cin   [DW];
	logic [NUMW-1:0]   rnx   [DW];
	logic [DW-1:0]     qnx   [DW];

	always_comb begin
		for (int k = 0; k < DW; k++) begin
			logic [CMPW-1:0] dsh;
			logic            ge;
			if (k == 0) begin
				rin[k] = num_mag;
				qin[k] = '0;
				din[k] = det_mag;
				cin[k] = ctl_in;
			end else begin
				rin[k] = rem_q[k-1];
				qin[k] = quo_q[k-1];
				din[k] = det_q[k-1];
				cin[k] = ctl_q[k-1];
			end
			dsh = CMPW'(din[k]) << (DW - 1 - k);
			ge  = CMPW'(rin[k]) >= dsh;
			rnx[k] = ge ? (rin[k] - dsh[NUMW-1:0]) : rin[k];
			qnx[k] = qin[k];
			qnx[k][DW-1-k] = ge;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DW; k++) begin
			if (en[k]) begin
				rem_q[k] <= rnx[k];
				quo_q[k] <= qnx[k];
				det_q[k] <= din[k];
				ctl_q[k] <= cin[k];
			end
		end
	end

	assign quo     = quo_q[DW-1];
	assign ctl_out = ctl_q[DW-1];

endmodule
`default_nettype wire

// File: src/rigid_body_angular_acceleration.sv
// Top level: Euler rotation step, angular acceleration from rate and torque.
// Usage: six inertia registers (xx, yy, zz, xy, xz, yz, Q16.16) are written on the cfg
// channel while no item is in flight; cfg_ready is always high. Each beat on s_axis
// carries rate x/y/z and moment x/y/z; each beat on m_axis returns accel x/y/z with the
// singular and overflow flags in tuser.
// The pipeline has eight arithmetic stages, one restoring-divider stage per quotient bit, and
// the output register. Throughput is one beat per cycle while the output is not stalled;
// the divider stages set the depth.
// Every stage has its own valid bit and moves when it is empty or its successor moves, so
// a stalled receiver holds the output beat and the pipeline keeps taking input until all
// stages are full; nothing is lost or repeated.
// Reset clears the valid bits and loads the identity tensor. The adjugate and determinant
// are recomputed from the registers in a pipeline of their own, shorter than the path an
// item takes to reach them.
`default_nettype none
module rigid_body_angular_acceleration #(
	parameter int DATA_WIDTH = rbaa_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = rbaa_pkg::FRAC_BITS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [rbaa_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [DATA_WIDTH-1:0]                 cfg_data,
	input  wire                                   s_axis_tvalid,
	output logic                                  s_axis_tready,
	// rate_x, rate_y, rate_z, moment_x, moment_y, moment_z
	input  wire  [((6*DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire                                   m_axis_tready,
	// accel_x, accel_y, accel_z
	output logic [((3*DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
	// singular, overflow
	output logic [1:0]                            m_axis_tuser
);
	localparam int DW   = DATA_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int PW   = 2 * DW;
	localparam int LSW  = 2 * DW + 2;
	localparam int CW   = 2 * DW;
	localparam int PRW  = 3 * DW;
	localparam int DETW = 3 * DW + 2;
	localparam int NUMW = DETW + F;
	localparam int NST  = DW + 9;
	localparam int ODW  = ((3*DATA_WIDTH+7)/8)*8;
	localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

	// Configuration registers.
	logic        [DW-2:0] ixx_q, iyy_q, izz_q;
	logic signed [DW-1:0] pxy_q, pxz_q, pyz_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ixx_q <= (DW-1)'(1) << F;
			iyy_q <= (DW-1)'(1) << F;
			izz_q <= (DW-1)'(1) << F;
			pxy_q <= '0;
			pxz_q <= '0;
			pyz_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rbaa_pkg::REG_INERTIA_XX: ixx_q <= cfg_data[DW-2:0];
				rbaa_pkg::REG_INERTIA_YY: iyy_q <= cfg_data[DW-2:0];
				rbaa_pkg::REG_INERTIA_ZZ: izz_q <= cfg_data[DW-2:0];
				rbaa_pkg::REG_PRODUCT_XY: pxy_q <= $signed(cfg_data);
				rbaa_pkg::REG_PRODUCT_XZ: pxz_q <= $signed(cfg_data);
				rbaa_pkg::REG_PRODUCT_YZ: pyz_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	logic signed [CW-1:0]  cof [6];
	logic        [DETW-1:0] det_mag;
	logic                  det_neg, det_zero;

	rbaa_adj #(.DATA_WIDTH(DW)) u_adj (
		.clk      (clk),
		.ixx      (ixx_q),
		.iyy      (iyy_q),
		.izz      (izz_q),
		.pxy      (pxy_q),
		.pxz      (pxz_q),
		.pyz      (pyz_q),
		.cof      (cof),
		.det_mag  (det_mag),
		.det_neg  (det_neg),
		.det_zero (det_zero)
	);

	// Stage valids and per-stage advance.
	logic [NST-1:0] vld_q;
	logic [NST-1:0] en;

	always_comb begin
		en[NST-1] = !vld_q[NST-1] || m_axis_tready;
		for (int k = NST - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign s_axis_tready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= s_axis_tvalid;
			end
			for (int k = 1; k < NST; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: tensor times rate.
	logic signed [DW-1:0] wi [3];
	logic signed [DW-1:0] ti [3];
	logic signed [DW-1:0] mat [3][3];
	logic signed [PW-1:0] prod_s1 [3][3];
	logic signed [DW-1:0] w_s1 [3];
	logic signed [DW-1:0] t_s1 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wi[i] = $signed(s_axis_tdata[i*DW +: DW]);
			ti[i] = $signed(s_axis_tdata[(3+i)*DW +: DW]);
		end
		mat[0][0] = $signed({1'b0, ixx_q});
		mat[1][1] = $signed({1'b0, iyy_q});
		mat[2][2] = $signed({1'b0, izz_q});
		mat[0][1] = pxy_q;  mat[1][0] = pxy_q;
		mat[0][2] = pxz_q;  mat[2][0] = pxz_q;
		mat[1][2] = pyz_q;  mat[2][1] = pyz_q;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s1[i][j] <= mat[i][j] * wi[j];
				end
				w_s1[i] <= wi[i];
				t_s1[i] <= ti[i];
			end
		end
	end

	// Stage 2: angular momentum, floored and saturated.
	logic signed [LSW-1:0] lsh [3];
	logic signed [DW-1:0]  lsat [3];
	logic [2:0]            lovf;
	logic signed [DW-1:0]  l_s2 [3];
	logic signed [DW-1:0]  w_s2 [3];
	logic signed [DW-1:0]  t_s2 [3];
	logic                  ovf_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lsh[i] = (LSW'(prod_s1[i][0]) + LSW'(prod_s1[i][1]) + LSW'(prod_s1[i][2])) >>> F;
			lovf[i] = !((lsh[i][LSW-1:DW-1] == '0) || (lsh[i][LSW-1:DW-1] == '1));
			lsat[i] = !lovf[i] ? lsh[i][DW-1:0] : (lsh[i][LSW-1] ? SMIN : SMAX);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			l_s2   <= lsat;
			w_s2   <= w_s1;
			t_s2   <= t_s1;
			ovf_s2 <= |lovf;
		end
	end

	// Stage 3: cross-product terms.
	logic signed [PW-1:0] gp_s3 [3][2];
	logic signed [DW-1:0] t_s3 [3];
	logic                 ovf_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				gp_s3[i][0] <= w_s2[(i+1)%3] * l_s2[(i+2)%3];
				gp_s3[i][1] <= w_s2[(i+2)%3] * l_s2[(i+1)%3];
			end
			t_s3   <= t_s2;
			ovf_s3 <= ovf_s2;
		end
	end

	// Stage 4: torque minus gyroscopic term.
	logic signed [PW:0]    gyro [3];
	logic signed [PW+1:0]  rdif [3];
	logic [2:0]            rovf;
	logic signed [DW-1:0]  rsat [3];
	logic signed [DW-1:0]  r_s4 [3];
	logic                  ovf_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			gyro[i] = ((PW+1)'(gp_s3[i][0]) - (PW+1)'(gp_s3[i][1])) >>> F;
			rdif[i] = (PW+2)'(t_s3[i]) - (PW+2)'(gyro[i]);
			rovf[i] = !((rdif[i][PW+1:DW-1] == '0) || (rdif[i][PW+1:DW-1] == '1));
			rsat[i] = !rovf[i] ? rdif[i][DW-1:0] : (rdif[i][PW+1] ? SMIN : SMAX);
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			r_s4   <= rsat;
			ovf_s4 <= ovf_s3 | (|rovf);
		end
	end

	// Stage 5: adjugate times residual, split into two half products each.
	logic signed [PW:0]   plo_s5 [3][3];
	logic signed [PW-1:0] phi_s5 [3][3];
	logic                 ovf_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					plo_s5[i][j] <= $signed({1'b0, cof[rbaa_pkg::cof_sel(i, j)][DW-1:0]})
						* r_s4[j];
					phi_s5[i][j] <= $signed(cof[rbaa_pkg::cof_sel(i, j)][CW-1:DW]) * r_s4[j];
				end
			end
			ovf_s5 <= ovf_s4;
		end
	end

	// Stage 6: recombine the half products.
	logic signed [PRW-1:0] prod_s6 [3][3];
	logic                  ovf_s6;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s6[i][j] <= (PRW'(phi_s5[i][j]) <<< DW) + PRW'(plo_s5[i][j]);
				end
			end
			ovf_s6 <= ovf_s5;
		end
	end

	// Stage 7: numerator, scaled and split into sign and magnitude.
	logic signed [DETW-1:0] nsum [3];
	logic        [NUMW-1:0] nsh [3];
	logic [NUMW-1:0]        mag_s7 [3];
	logic [2:0]             neg_s7;
	logic                   sing_s7;
	logic                   ovf_s7;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nsum[i] = DETW'(prod_s6[i][0]) + DETW'(prod_s6[i][1]) + DETW'(prod_s6[i][2]);
			nsh[i]  = {nsum[i], {F{1'b0}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int i = 0; i < 3; i++) begin
				neg_s7[i] <= nsum[i][DETW-1] ^ det_neg;
				mag_s7[i] <= nsum[i][DETW-1] ? (NUMW'(0) - nsh[i]) : nsh[i];
			end
			sing_s7 <= det_zero;
			ovf_s7  <= ovf_s6;
		end
	end

	// Stage 8: quotient range check against det * 2^DW.
	localparam int CMPW = (NUMW > DETW + DW) ? NUMW : DETW + DW;
	logic [NUMW-1:0]  mag_s8 [3];
	rbaa_pkg::dctl_t  ctl_s8 [3];

	always_ff @(posedge clk) begin
		if (en[7]) begin
			for (int i = 0; i < 3; i++) begin
				mag_s8[i]      <= mag_s7[i];
				ctl_s8[i].big  <= CMPW'(mag_s7[i]) >= (CMPW'(det_mag) << DW);
				ctl_s8[i].neg  <= neg_s7[i];
				ctl_s8[i].sing <= sing_s7;
				ctl_s8[i].ovf  <= ovf_s7;
			end
		end
	end

	// Divider per axis.
	logic [DW-1:0]   quo [3];
	rbaa_pkg::dctl_t dctl [3];

	for (genvar a = 0; a < 3; a++) begin : g_div
		rbaa_div #(.DATA_WIDTH(DW), .NUMW(NUMW), .DETW(DETW)) u_div (
			.clk     (clk),
			.en      (en[8 +: DW]),
			.num_mag (mag_s8[a]),
			.det_mag (det_mag),
			.ctl_in  (ctl_s8[a]),
			.quo     (quo[a]),
			.ctl_out (dctl[a])
		);
	end

	// Output stage: sign, saturation and the singular case.
	logic signed [DW-1:0] acc [3];
	logic [2:0]           aovf;
	logic signed [DW-1:0] acc_q [3];
	logic                 sing_q, ovf_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dctl[i].big) begin
				aovf[i] = 1'b1;
				acc[i]  = dctl[i].neg ? SMIN : SMAX;
			end else if (dctl[i].neg) begin
				aovf[i] = quo[i][DW-1] && (|quo[i][DW-2:0]);
				acc[i]  = aovf[i] ? SMIN : $signed(DW'(0) - quo[i]);
			end else begin
				aovf[i] = quo[i][DW-1];
				acc[i]  = aovf[i] ? SMAX : $signed(quo[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			sing_q <= dctl[0].sing;
			if (dctl[0].sing) begin
				for (int i = 0; i < 3; i++) begin
					acc_q[i] <= '0;
				end
				ovf_q <= 1'b0;
			end else begin
				acc_q <= acc;
				ovf_q <= dctl[0].ovf | (|aovf);
			end
		end
	end

	assign m_axis_tvalid = vld_q[NST-1];
	assign m_axis_tdata  = ODW'({acc_q[2], acc_q[1], acc_q[0]});
	assign m_axis_tuser  = {ovf_q, sing_q};

endmodule
`default_nettype wire
